FILE: rtl/dq_pkg.sv
package dq_pkg;

    localparam int CAPACITY = 16;
    localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int SUM_W    = CNT_W + 1;
    localparam int WORD_W   = 32;
    localparam int OCC_W    = 5;

    localparam logic signed [WORD_W-1:0] MOST_NEG_WORD = {1'b1, {(WORD_W-1){1'b0}}};

    typedef enum logic [1:0] {
        MODE_PUSH_FRONT = 2'd0,
        MODE_PUSH_REAR  = 2'd1,
        MODE_POP_FRONT  = 2'd2,
        MODE_POP_REAR   = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        STATUS_DONE  = 2'd0,
        STATUS_EMPTY = 2'd1,
        STATUS_FULL  = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_SEND
    } state_t;

    typedef struct packed {
        mode_t                     mode;
        logic signed [WORD_W-1:0]  value;
    } in_item_t;

    typedef struct packed {
        logic signed [WORD_W-1:0]  popped_value;
        status_t                   status;
        logic [OCC_W-1:0]          occupancy;
    } out_item_t;

endpackage

FILE: rtl/double_ended_queue_top.sv
// A push result is offered in the cycle after its transfer; a pop result passes ST_READ, then ST_SEND.
// Requests are taken one at a time: in_stall holds off a new request until the result has been taken
// at the output; the pop path is longer because the slot memory read is registered in rdata_reg.
// Reset (rst_n low, asynchronous) empties the queue and clears the head index;
// the slot memory itself is not cleared, and only slots holding stored words are read.
module double_ended_queue_top
    import dq_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_stall,
    input  in_item_t  in_data,
    output logic      out_valid,
    input  logic      out_stall,
    output out_item_t out_data
);

    logic signed [WORD_W-1:0] slots [CAPACITY];

    state_t             state_reg, state_next;
    logic [IDX_W-1:0]   head_reg, head_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    out_item_t          result_reg, result_next;
    logic signed [WORD_W-1:0] rdata_reg;

    logic               mem_we;
    logic               mem_re;
    logic [IDX_W-1:0]   mem_addr;

    logic               accept;
    logic               is_push;
    logic               is_full;
    logic               is_empty;
    logic [IDX_W-1:0]   head_dec;
    logic [IDX_W-1:0]   head_inc;
    logic [SUM_W-1:0]   rear_sum;
    logic [SUM_W-1:0]   last_sum;
    logic [IDX_W-1:0]   rear_pos;
    logic [IDX_W-1:0]   last_pos;

    assign accept   = in_valid && !in_stall;
    assign is_push  = (in_data.mode == MODE_PUSH_FRONT) || (in_data.mode == MODE_PUSH_REAR);
    assign is_full  = (count_reg >= CNT_W'(CAPACITY));
    assign is_empty = (count_reg == '0);

    assign head_dec = (head_reg == '0) ? IDX_W'(CAPACITY - 1) : head_reg - 1'b1;
    assign head_inc = (head_reg == IDX_W'(CAPACITY - 1)) ? '0 : head_reg + 1'b1;

    // Both sums stay below twice the capacity where they are used, so one conditional subtract wraps them.
    assign rear_sum = SUM_W'(head_reg) + SUM_W'(count_reg);
    assign last_sum = rear_sum - 1'b1;
    assign rear_pos = (rear_sum >= SUM_W'(CAPACITY))
                      ? IDX_W'(rear_sum - SUM_W'(CAPACITY)) : IDX_W'(rear_sum);
    assign last_pos = (last_sum >= SUM_W'(CAPACITY))
                      ? IDX_W'(last_sum - SUM_W'(CAPACITY)) : IDX_W'(last_sum);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            head_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            head_reg  <= head_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            slots[mem_addr] <= in_data.value;
        end
        if (mem_re)
        begin
            rdata_reg <= slots[mem_addr];
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        head_next   = head_reg;
        count_next  = count_reg;
        result_next = result_reg;
        mem_we      = 1'b0;
        mem_re      = 1'b0;
        mem_addr    = head_reg;
        in_stall    = 1'b1;
        out_valid   = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (accept)
                begin
                    result_next.popped_value = '0;
                    result_next.status       = STATUS_DONE;
                    state_next               = ST_SEND;
                    if (is_push)
                    begin
                        if (is_full)
                        begin
                            result_next.status = STATUS_FULL;
                        end
                        else
                        begin
                            mem_we     = 1'b1;
                            count_next = count_reg + 1'b1;
                            if (in_data.mode == MODE_PUSH_FRONT)
                            begin
                                mem_addr  = head_dec;
                                head_next = head_dec;
                            end
                            else
                            begin
                                mem_addr = rear_pos;
                            end
                        end
                    end
                    else
                    begin
                        if (is_empty)
                        begin
                            result_next.popped_value = MOST_NEG_WORD;
                            result_next.status       = STATUS_EMPTY;
                        end
                        else
                        begin
                            mem_re     = 1'b1;
                            count_next = count_reg - 1'b1;
                            state_next = ST_READ;
                            if (in_data.mode == MODE_POP_FRONT)
                            begin
                                mem_addr  = head_reg;
                                head_next = head_inc;
                            end
                            else
                            begin
                                mem_addr = last_pos;
                            end
                        end
                    end
                    result_next.occupancy = OCC_W'(count_next);
                end
            end
            ST_READ:
            begin
                result_next.popped_value = rdata_reg;
                state_next               = ST_SEND;
            end
            ST_SEND:
            begin
                out_valid = 1'b1;
                if (!out_stall)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign out_data = result_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("element count exceeds capacity");

    assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg != ST_IDLE))
        else $error("accepted request left the queue idle");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |=> $stable(count_reg) && $stable(head_reg))
        else $error("queue state moved while a request was in flight");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_data.status == STATUS_FULL) |-> out_data.occupancy == OCC_W'(CAPACITY))
        else $error("full status without a full queue");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_data.status == STATUS_EMPTY)
            |-> (out_data.popped_value == MOST_NEG_WORD) && (out_data.occupancy == '0))
        else $error("empty status with a wrong result");

endmodule

FILE: sim/testbench.sv
`timescale 1ns / 100ps

module testbench;
    import dq_pkg::*;

    localparam int RUN_LIMIT       = 60000;
    localparam int RANDOM_REQUESTS = 550;
    localparam int DRAIN_CYCLES    = 8;
    localparam int IDLE_PERCENT    = 26;
    localparam int REPORT_CAP      = 40;
    localparam logic signed [WORD_W-1:0] MOST_POS_WORD = {1'b0, {(WORD_W-1){1'b1}}};

    // Mirrors the ring buffer and keeps the responses that are still owed.
    class deque_scoreboard;
        logic signed [WORD_W-1:0] slot_words [CAPACITY];
        logic [IDX_W-1:0]         front_slot;
        logic [OCC_W-1:0]         stored;
        out_item_t                awaited_responses [$];
        int                       requests;
        int                       responses;
        int                       mismatches;
        int                       dropped_pushes;
        int                       empty_pops;
        int                       peak_fill;

        function new();
            front_slot     = '0;
            stored         = '0;
            requests       = 0;
            responses      = 0;
            mismatches     = 0;
            dropped_pushes = 0;
            empty_pops     = 0;
            peak_fill      = 0;
        endfunction

        function void note_request(in_item_t req);
            out_item_t        resp;
            logic [IDX_W-1:0] pos;
            resp.popped_value = '0;
            resp.status       = STATUS_DONE;
            requests++;
            if (req.mode == MODE_PUSH_FRONT || req.mode == MODE_PUSH_REAR)
            begin
                if (stored >= CAPACITY)
                begin
                    resp.status = STATUS_FULL;
                    dropped_pushes++;
                end
                else
                begin
                    if (req.mode == MODE_PUSH_FRONT)
                    begin
                        front_slot = front_slot - 1'b1;
                        pos        = front_slot;
                    end
                    else
                    begin
                        pos = front_slot + stored[IDX_W-1:0];
                    end
                    slot_words[pos] = req.value;
                    stored++;
                end
            end
            else if (stored == 0)
            begin
                resp.popped_value = MOST_NEG_WORD;
                resp.status       = STATUS_EMPTY;
                empty_pops++;
            end
            else if (req.mode == MODE_POP_FRONT)
            begin
                resp.popped_value = slot_words[front_slot];
                front_slot++;
                stored--;
            end
            else
            begin
                pos               = front_slot + stored[IDX_W-1:0] - 1'b1;
                resp.popped_value = slot_words[pos];
                stored--;
            end
            if (stored > peak_fill)
                peak_fill = stored;
            resp.occupancy = stored;
            awaited_responses.push_back(resp);
        endfunction

        function void report_mismatch(string field, logic signed [WORD_W-1:0] want,
                                      logic signed [WORD_W-1:0] got);
            mismatches++;
            if (mismatches <= REPORT_CAP)
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
        endfunction

        function void check_result(out_item_t got);
            out_item_t want;
            responses++;
            if (awaited_responses.size() == 0)
            begin
                report_mismatch("unexpected transfer popped_value", 0, got.popped_value);
                return;
            end
            want = awaited_responses.pop_front();
            if (got.popped_value !== want.popped_value)
                report_mismatch("popped_value", want.popped_value, got.popped_value);
            if (got.status !== want.status)
                report_mismatch("status", want.status, got.status);
            if (got.occupancy !== want.occupancy)
                report_mismatch("occupancy", want.occupancy, got.occupancy);
        endfunction
    endclass

    logic      clk = 1'b0;
    logic      rst_n;
    logic      in_valid;
    logic      in_stall;
    in_item_t  in_data;
    logic      out_valid;
    logic      out_stall;
    out_item_t out_data;
    logic      steady;
    int        cycle_count = 0;

    deque_scoreboard board;

    double_ended_queue_top uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > RUN_LIMIT)
        begin
            $display("Timed out after %0d cycles", cycle_count);
            $display("Regression FAIL");
            $finish;
        end
    end

    // Sampling happens before this edge's updates land, so values are the ones the block saw.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            board.check_result(out_data);
        out_stall <= !steady && ($urandom_range(99) < IDLE_PERCENT);
    end

    function automatic in_item_t make_request(mode_t mode, logic signed [WORD_W-1:0] value);
        in_item_t req;
        req.mode  = mode;
        req.value = value;
        return req;
    endfunction

    // Returns at the edge where the transfer happens.
    task automatic send_request(in_item_t req);
        while (!steady && $urandom_range(99) < IDLE_PERCENT)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= req;
        do
            @(posedge clk);
        while (in_stall);
        board.note_request(req);
    endtask

    initial
    begin
        logic signed [WORD_W-1:0] corner_words [4];
        in_item_t                 req;
        int                       push_percent;
        board           = new();
        corner_words[0] = MOST_NEG_WORD;
        corner_words[1] = MOST_POS_WORD;
        corner_words[2] = '0;
        corner_words[3] = '1;
        push_percent    = 75;
        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        in_data   <= '0;
        out_stall <= 1'b0;
        steady    <= 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Pops on an empty queue, then the extreme words through both ends.
        send_request(make_request(MODE_POP_FRONT, 32'sh1234_5678));
        send_request(make_request(MODE_POP_REAR, MOST_NEG_WORD));
        send_request(make_request(MODE_PUSH_FRONT, MOST_NEG_WORD));
        send_request(make_request(MODE_PUSH_REAR, MOST_POS_WORD));
        send_request(make_request(MODE_POP_REAR, '0));
        send_request(make_request(MODE_POP_FRONT, '1));

        // Fill to capacity, then pushes at both ends must be dropped.
        for (int i = 0; i < CAPACITY; i++)
            send_request(make_request((i % 2) ? MODE_PUSH_REAR : MODE_PUSH_FRONT,
                                      (i < 4) ? corner_words[i] : $urandom()));
        send_request(make_request(MODE_PUSH_FRONT, 32'sh0BAD_0001));
        send_request(make_request(MODE_PUSH_REAR, 32'sh0BAD_0002));
        send_request(make_request(MODE_POP_FRONT, '0));
        send_request(make_request(MODE_POP_REAR, '0));

        // Push-heavy and pop-heavy runs alternate so the queue keeps hitting full and empty.
        for (int n = 0; n < RANDOM_REQUESTS; n++)
        begin
            if (n % 30 == 0)
                push_percent = ((n / 30) % 2) ? 25 : 75;
            steady <= (n >= 250 && n < 390);
            if ($urandom_range(99) < push_percent)
                req.mode = mode_t'($urandom_range(1));
            else
                req.mode = mode_t'($urandom_range(3, 2));
            if ($urandom_range(9) == 0)
                req.value = corner_words[$urandom_range(3)];
            else
                req.value = $urandom();
            send_request(req);
        end
        in_valid <= 1'b0;

        while (board.awaited_responses.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Covered %0d requests and %0d responses, peak fill %0d of %0d.",
                 board.requests, board.responses, board.peak_fill, CAPACITY);
        $display("Pushes dropped on a full queue: %0d, pops on an empty queue: %0d.",
                 board.dropped_pushes, board.empty_pops);
        if (board.mismatches == 0 && board.awaited_responses.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

FILE: sim.f
rtl/dq_pkg.sv
rtl/double_ended_queue_top.sv
sim/testbench.sv
